// File: rtl/mvcv_pkg.sv
package mvcv_pkg;

  localparam logic [1:0] REQ_NOTE     = 2'd0;
  localparam logic [1:0] REQ_BEND     = 2'd1;
  localparam logic [1:0] REQ_CTRL     = 2'd2;
  localparam logic [1:0] REQ_PRESSURE = 2'd3;

  localparam logic [2:0] OUTLET_GATE   = 3'd0;
  localparam logic [2:0] OUTLET_PITCH  = 3'd1;
  localparam logic [2:0] OUTLET_GLIDE  = 3'd2;
  localparam logic [2:0] OUTLET_SLIDE  = 3'd3;
  localparam logic [2:0] OUTLET_PRESS  = 3'd4;
  localparam logic [2:0] OUTLET_STRIKE = 3'd5;

  localparam logic [6:0] CTRL_TIMBRE = 7'd74;
  localparam logic [13:0] BEND_CENTRE = 14'd8192;

  // Q1.14 scaling of a 7-bit level: round(v * 16384 / 127)
  // 16384 = 127 * 129 + 1, so the rounded value is 129 * v, plus one when v >= 64
  function automatic logic [14:0] unit_scale(input logic [6:0] v);
    unit_scale = {1'b0, v, 7'd0} + {8'd0, v} + {14'd0, v[6]};
  endfunction

endpackage

// File: rtl/mvcv_pitch.sv
// 2^(r/98304) scaled to Hz in Q20.8. Multiplies run bit-serially, one
// multiplier bit per cycle; division by k uses a restoring divider, one bit per cycle.
module mvcv_pitch (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [22:0]  expo_i,
  output logic                done_o,
  output logic [28:0]         pitch_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVQ = 3'd1;
  localparam logic [2:0] S_ZMUL = 3'd2;
  localparam logic [2:0] S_ZDIV = 3'd3;
  localparam logic [2:0] S_HMUL = 3'd4;
  localparam logic [2:0] S_HDIV = 3'd5;
  localparam logic [2:0] S_FMUL = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [3:0]  k_q, k_d;
  logic [4:0]  oct_q, oct_d;       // octave count q + 12
  logic [63:0] acc_q, acc_d;       // product / numerator accumulator
  logic [63:0] mcand_q, mcand_d;   // shifted multiplicand
  logic [35:0] mplier_q, mplier_d; // multiplier bits, LSB first
  logic [63:0] quo_q, quo_d;       // dividend shifted out / quotient in
  logic [36:0] rem_q, rem_d;
  logic [30:0] z_q, z_d;
  logic [31:0] m_q, m_d;
  logic [28:0] res_q, res_d;

  logic [36:0] rtry;
  logic [37:0] rsh;
  logic [36:0] divisor;
  logic [5:0]  sh;
  logic [63:0] rnd;

  always_comb begin
    unique case (state_q)
      S_DIVQ:  divisor = 37'd98304;
      default: divisor = {33'd0, k_q};
    endcase
    rsh  = {rem_q, quo_q[63]};
    rtry = 37'(rsh - {1'b0, divisor});
    sh   = 6'(6'd42 - {1'b0, oct_q});
    rnd  = 64'd1 << (sh - 6'd1);
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; k_d = k_q; oct_d = oct_q;
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    quo_d = quo_q; rem_d = rem_q; z_d = z_q; m_d = m_q; res_d = res_q;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        // bias by 12 octaves so the value is nonnegative
        quo_d = {41'd0, 23'(expo_i + 23'sd1179648)} << 41;
        rem_d = '0; cnt_d = 6'd23; state_d = S_DIVQ;
      end
      S_DIVQ: begin
        // restoring division by 98304, one quotient bit per cycle
        quo_d = {quo_q[62:0], ~rtry[36] & ~rsh[37]};
        rem_d = (rsh[37] || !rtry[36]) ? 37'(rsh - {1'b0, divisor}) : rsh[36:0];
        if (rsh[37] || !rtry[36]) quo_d[0] = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          oct_d = 5'(quo_d[4:0]);
          acc_d = '0; mcand_d = {47'd0, rem_d[16:0]};
          mplier_d = {6'd0, 30'd744261118}; cnt_d = 6'd30; state_d = S_ZMUL;
        end
      end
      S_ZMUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = mcand_q << 1; mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          // acc / 98304 = (acc >> 15) / 3
          quo_d = (acc_d >> 15) << 16; rem_d = '0; k_d = 4'd3;
          cnt_d = 6'd48; state_d = S_ZDIV;
        end
      end
      S_ZDIV, S_HDIV: begin
        quo_d = {quo_q[62:0], !rtry[36]};
        rem_d = !rtry[36] ? rtry : rsh[36:0];
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          if (state_q == S_ZDIV) begin
            z_d = 31'(quo_d); m_d = 32'h4000_0000; k_d = 4'd10;
          end else begin
            m_d = 32'(32'h4000_0000 + quo_d[31:0]);
            k_d = k_q - 4'd1;
          end
          if (state_q == S_HDIV && k_q == 4'd1) begin
            acc_d = '0; mcand_d = {32'd0, m_d}; mplier_d = 36'd112640;
            cnt_d = 6'd17; state_d = S_FMUL;
          end else begin
            acc_d = '0; mcand_d = {33'd0, z_d}; mplier_d = {4'd0, m_d};
            cnt_d = 6'd32; state_d = S_HMUL;
          end
        end
      end
      S_HMUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = mcand_q << 1; mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          quo_d = (acc_d >> 30) << 30; rem_d = '0; cnt_d = 6'd34; state_d = S_HDIV;
        end
      end
      S_FMUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = mcand_q << 1; mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d = 29'((acc_d + rnd) >> sh); state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_o = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; oct_q <= oct_d; acc_q <= acc_d; mcand_q <= mcand_d;
    mplier_q <= mplier_d; quo_q <= quo_d; rem_q <= rem_d; z_q <= z_d;
    m_q <= m_d; res_q <= res_d;
  end

  assign pitch_o = res_q;

endmodule

// File: rtl/midi_voice_to_control_values_unit.sv
// channel | handshake           | payload
// in      | in_valid / in_stall | req_type, note_number, event_value, controller_number
// out     | out_valid/out_stall | outlet_id, control_value, last_of_run
// cfg     | cfg_valid/cfg_ready | cfg_data_i (semitones at full bend)
// One event at a time. An event with pitch runs a bit-serial multiply/divide unit
// (ten Horner steps) and emits its words once the pitch value is ready.
// While a word waits on a stalled output, the output holds.
// Reset clears voice state and sets the bend range to 2.
module midi_voice_to_control_values_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  note_number_i,
  input  logic [13:0] event_value_i,
  input  logic [6:0]  controller_number_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outlet_id_o,
  output logic signed [28:0] control_value_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data_i
);
  import mvcv_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PITCH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  range_q;
  logic [6:0]  note_q, vel_q, timbre_q, press_q;
  logic [13:0] bend_q;
  logic        active_q;
  logic [5:0]  mask_q, mask_d;     // outlets still to emit
  logic        zero_q, zero_d;
  logic [28:0] pitch_q;
  // registered start for pitch, high once the new note and bend are registered, so expo sees new state
  logic        pkick_q;
  logic        pdone;
  logic [28:0] pres;
  logic signed [22:0] expo;
  logic [2:0]  id;
  logic signed [28:0] val;
  logic [6:0]  sat;
  logic        accept;
  logic [5:0]  rest;
  logic        obusy;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign sat = (event_value_i > 14'd127) ? 7'd127 : event_value_i[6:0];

  assign expo = 23'(($signed({1'b0, note_q}) - 9'sd69) * 23'sd8192)
              + 23'($signed({1'b0, bend_q}) - $signed({1'b0, BEND_CENTRE}))
                * $signed({1'b0, range_q});

  mvcv_pitch u_pitch (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(pkick_q), .expo_i(expo),
    .done_o(pdone), .pitch_o(pres)
  );

  // lowest pending outlet
  always_comb begin
    id = OUTLET_STRIKE;
    for (int i = 5; i >= 0; i--) if (mask_q[i]) id = 3'(i);
    rest = mask_q & ~(6'd1 << id);
  end

  always_comb begin
    logic signed [15:0] g;
    logic signed [8:0]  n;
    logic [14:0] s;
    g = 16'sd0; n = 9'sd0; s = 15'd0;
    val = '0;
    if (!zero_q) begin
      unique case (id)
        OUTLET_GATE:  val = 29'sd16384;
        OUTLET_PITCH: val = $signed(pitch_q);
        OUTLET_GLIDE: begin
          if (bend_q > 14'd8355) val = 29'sd16384;
          else if (bend_q < 14'd8029) val = -29'sd16384;
          else begin
            g = 16'(($signed({2'b0, bend_q}) - 16'sd8192) * 16'sd100);
            val = 29'(g);
          end
        end
        OUTLET_SLIDE: begin
          n = $signed({1'b0, timbre_q, 1'b0}) - 9'sd127;
          s = unit_scale(7'(n < 0 ? -n : n));
          val = n < 0 ? -29'($signed({1'b0, s})) : 29'($signed({1'b0, s}));
        end
        OUTLET_PRESS: val = 29'($signed({1'b0, unit_scale(press_q)}));
        default:      val = 29'($signed({1'b0, unit_scale(vel_q)}));
      endcase
    end
  end

  assign obusy = out_valid && out_stall;

  always_comb begin
    state_d = state_q; mask_d = mask_q; zero_d = zero_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        zero_d = 1'b0; mask_d = '0;
        unique case (req_type_i)
          REQ_NOTE: begin
            mask_d = 6'b111111;
            zero_d = (event_value_i == 14'd0);
          end
          REQ_BEND:     if (active_q) mask_d = 6'b000110;
          REQ_CTRL:     if (active_q && controller_number_i == CTRL_TIMBRE) mask_d = 6'b001000;
          default:      if (active_q) mask_d = 6'b010000;
        endcase
        if (mask_d != '0) state_d = (mask_d[1] && !zero_d) ? S_PITCH : S_EMIT;
      end
      S_PITCH: if (pdone) state_d = S_EMIT;
      S_EMIT: if (!obusy) begin
        mask_d = rest;
        if (rest == '0) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mask_q <= '0; zero_q <= 1'b0; range_q <= 6'd2;
      note_q <= '0; vel_q <= '0; bend_q <= BEND_CENTRE; timbre_q <= 7'd64;
      press_q <= '0; active_q <= 1'b0; pkick_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_q <= state_d; mask_q <= mask_d; zero_q <= zero_d;
      pkick_q <= (state_q == S_IDLE) && (state_d == S_PITCH);
      if (cfg_valid && cfg_ready) range_q <= cfg_data_i;
      if (accept) begin
        unique case (req_type_i)
          REQ_NOTE: if (event_value_i == 14'd0) begin
            note_q <= '0; vel_q <= '0; bend_q <= BEND_CENTRE; timbre_q <= 7'd64;
            press_q <= '0; active_q <= 1'b0;
          end else begin
            note_q <= note_number_i; vel_q <= sat; active_q <= 1'b1;
          end
          REQ_BEND: bend_q <= event_value_i;
          REQ_CTRL: if (controller_number_i == CTRL_TIMBRE) timbre_q <= sat;
          default:  press_q <= sat;
        endcase
      end
      if (state_q == S_EMIT && !obusy) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pdone) pitch_q <= pres;
    if (state_q == S_EMIT && !obusy) begin
      outlet_id_o <= id; control_value_o <= val; last_of_run_o <= (rest == '0);
    end
  end

endmodule

// File: sim/mvcv_checker.sv
module mvcv_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        req_type_i,
  input  logic [6:0]        note_number_i,
  input  logic [13:0]       event_value_i,
  input  logic [6:0]        controller_number_i,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        outlet_id_i,
  input  logic signed [28:0] control_value_i,
  input  logic              last_of_run_i,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [5:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_count_o,
  output int                word_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvcv_pkg::*;

  typedef struct {
    logic [2:0]         outlet;
    logic signed [28:0] value;
    logic               last;
  } control_word_t;

  control_word_t   expected_words[$];
  logic [5:0]      semis_q;
  logic [6:0]      note_q, velocity_q, timbre_q, pressure_q;
  logic [13:0]     bend_q;
  logic            active_q;

  function automatic logic [6:0] clip7(input logic [13:0] v);
    return (v > 14'd127) ? 7'd127 : v[6:0];
  endfunction

  function automatic longint q14_level(input logic [6:0] v);
    return (longint'(v) * 16384 + 63) / 127;
  endfunction

  function automatic longint slide_q14(input logic [6:0] t);
    longint n;
    longint m;
    n = 2 * longint'(t) - 127;
    m = (((n < 0) ? -n : n) * 16384 + 63) / 127;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint glide_q14(input logic [13:0] b);
    longint g;
    g = (longint'(b) - 8192) * 100;
    if (g > 16384) g = 16384;
    if (g < -16384) g = -16384;
    return g;
  endfunction

  // 2^(r/98304) by a truncated Horner series of e^z in Q30, then scale 440 Hz in Q20.8
  function automatic longint pitch_hz(input logic [6:0] nt, input logic [13:0] b,
                                      input logic [5:0] rng);
    longint          e;
    longint          q;
    longint unsigned eu, r, z, acc;
    int              shift;
    e = (longint'(nt) - 69) * 8192 + (longint'(b) - 8192) * longint'(rng);
    eu = longint'(e + 12 * 98304);
    q = longint'(eu / 98304) - 12;
    r = eu % 98304;
    z = (r * 64'd744261118) / 98304;
    acc = 64'd1 << 30;
    for (int k = 10; k >= 1; k--)
      acc = (64'd1 << 30) + ((acc * z) >> 30) / longint'(k);
    shift = 30 - int'(q);
    return longint'((64'd112640 * acc + (64'd1 << (shift - 1))) >> shift);
  endfunction

  function automatic void push_word(input logic [2:0] id, input longint v);
    control_word_t w;
    w.outlet = id;
    w.value = v[28:0];
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  task automatic apply_event();
    int first;
    first = expected_words.size();
    case (req_type_i)
      REQ_NOTE: begin
        if (event_value_i == 14'd0) begin
          note_q = '0; velocity_q = '0; bend_q = BEND_CENTRE;
          timbre_q = 7'd64; pressure_q = '0; active_q = 1'b0;
          push_word(OUTLET_GATE, 0);
          push_word(OUTLET_PITCH, 0);
          push_word(OUTLET_GLIDE, 0);
          push_word(OUTLET_SLIDE, 0);
          push_word(OUTLET_PRESS, 0);
          push_word(OUTLET_STRIKE, 0);
        end else begin
          note_q = note_number_i;
          velocity_q = clip7(event_value_i);
          active_q = 1'b1;
          push_word(OUTLET_GATE, 16384);
          push_word(OUTLET_PITCH, pitch_hz(note_q, bend_q, semis_q));
          push_word(OUTLET_GLIDE, glide_q14(bend_q));
          push_word(OUTLET_SLIDE, slide_q14(timbre_q));
          push_word(OUTLET_PRESS, q14_level(pressure_q));
          push_word(OUTLET_STRIKE, q14_level(velocity_q));
        end
      end
      REQ_BEND: begin
        bend_q = event_value_i;
        if (active_q) begin
          push_word(OUTLET_PITCH, pitch_hz(note_q, bend_q, semis_q));
          push_word(OUTLET_GLIDE, glide_q14(bend_q));
        end
      end
      REQ_CTRL: begin
        if (controller_number_i == CTRL_TIMBRE) begin
          timbre_q = clip7(event_value_i);
          if (active_q) push_word(OUTLET_SLIDE, slide_q14(timbre_q));
        end
      end
      default: begin
        pressure_q = clip7(event_value_i);
        if (active_q) push_word(OUTLET_PRESS, q14_level(pressure_q));
      end
    endcase
    if (expected_words.size() > first)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    control_word_t w;
    if (!rst_ni) begin
      expected_words.delete();
      semis_q = 6'd2;
      note_q = '0; velocity_q = '0; bend_q = BEND_CENTRE;
      timbre_q = 7'd64; pressure_q = '0; active_q = 1'b0;
      fail_count_o = 0;
      word_count_o = 0;
    end else begin
      if (out_valid && !out_stall) begin
        word_count_o++;
        if (expected_words.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word outlet %0d value %0d last %0b", $time,
                   outlet_id_i, control_value_i, last_of_run_i);
        end else begin
          w = expected_words.pop_front();
          if (w.outlet !== outlet_id_i || w.value !== control_value_i ||
              w.last !== last_of_run_i) begin
            fail_count_o++;
            $display("%0t: mismatch expected outlet %0d value %0d last %0b, got %0d %0d %0b",
                     $time, w.outlet, w.value, w.last,
                     outlet_id_i, control_value_i, last_of_run_i);
          end
        end
      end
      if (cfg_valid && cfg_ready) semis_q = cfg_data_i;
      if (in_valid && !in_stall) apply_event();
    end
    pending_count_o = expected_words.size();
  end

endmodule

// File: sim/tb_midi_voice_to_control_values_unit.sv
module tb_midi_voice_to_control_values_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mvcv_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 600;
  localparam int HoldCycles = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type_i = REQ_NOTE;
  logic [6:0]        note_number_i = '0;
  logic [13:0]       event_value_i = '0;
  logic [6:0]        controller_number_i = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [2:0]        outlet_id_o;
  logic signed [28:0] control_value_o;
  logic              last_of_run_o;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [5:0]        cfg_data_i = '0;

  int fail_count, pending_count, word_count;
  int tx_idle_pct = 32;
  int rx_idle_pct = 71;
  int events_sent = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  midi_voice_to_control_values_unit DUT (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .note_number_i,
    .event_value_i, .controller_number_i, .out_valid, .out_stall, .outlet_id_o,
    .control_value_o, .last_of_run_o, .cfg_valid, .cfg_ready, .cfg_data_i
  );

  mvcv_checker u_checker (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .note_number_i,
    .event_value_i, .controller_number_i, .out_valid, .out_stall,
    .outlet_id_i(outlet_id_o), .control_value_i(control_value_o),
    .last_of_run_i(last_of_run_o), .cfg_valid, .cfg_ready, .cfg_data_i,
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .word_count_o(word_count)
  );

  // receiver: random stall, with one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [6:0] nt,
                            input logic [13:0] v, input logic [6:0] ctrl);
    in_valid <= 1'b1;
    req_type_i <= kind;
    note_number_i <= nt;
    event_value_i <= v;
    controller_number_i <= ctrl;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    events_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    // events with no words may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_bend_range(input logic [5:0] rng);
    drain();
    cfg_valid <= 1'b1;
    cfg_data_i <= rng;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_event();
    int         pick;
    logic [13:0] v;
    logic [6:0]  ctrl;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 127));
    ctrl = 7'($urandom);
    if (pick < 25) begin
      if (v == 0) v = 14'd1;
      send_event(REQ_NOTE, 7'($urandom), v, ctrl);
    end else if (pick < 30) begin
      send_event(REQ_NOTE, 7'($urandom), 14'd0, ctrl);
    end else if (pick < 55) begin
      send_event(REQ_BEND, 7'($urandom), 14'($urandom), ctrl);
    end else if (pick < 75) begin
      send_event(REQ_CTRL, 7'($urandom), v, CTRL_TIMBRE);
    end else if (pick < 82) begin
      if (ctrl == CTRL_TIMBRE) ctrl = 7'd75;
      send_event(REQ_CTRL, 7'($urandom), v, ctrl);
    end else begin
      send_event(REQ_PRESSURE, 7'($urandom), v, ctrl);
    end
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == 0 && $urandom_range(0, 1) == 0)
        send_event(REQ_NOTE, 7'($urandom), 14'($urandom_range(1, 127)), '0);
      else
        random_event();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: inactive voice, extremes, wide values, clear
    send_event(REQ_BEND, 7'd0, 14'd16383, 7'd0);
    send_event(REQ_CTRL, 7'd0, 14'd100, CTRL_TIMBRE);
    send_event(REQ_PRESSURE, 7'd0, 14'd60, 7'd0);
    send_event(REQ_NOTE, 7'd69, 14'd100, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd0, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd16383, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd8192, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd8356, 7'd0);
    send_event(REQ_CTRL, 7'd0, 14'd0, CTRL_TIMBRE);
    send_event(REQ_CTRL, 7'd0, 14'd127, CTRL_TIMBRE);
    send_event(REQ_CTRL, 7'd0, 14'd16383, CTRL_TIMBRE);
    send_event(REQ_CTRL, 7'd0, 14'd50, 7'd10);
    send_event(REQ_CTRL, 7'd0, 14'd50, 7'd127);
    send_event(REQ_PRESSURE, 7'd0, 14'd127, 7'd0);
    send_event(REQ_PRESSURE, 7'd0, 14'd9000, 7'd0);
    send_event(REQ_NOTE, 7'd0, 14'd1, 7'd0);
    send_event(REQ_NOTE, 7'd127, 14'd16383, 7'd0);
    send_event(REQ_NOTE, 7'd127, 14'd0, 7'd0);
    send_event(REQ_PRESSURE, 7'd0, 14'd0, 7'd0);
    send_event(REQ_NOTE, 7'd60, 14'd128, 7'd0);

    set_bend_range(6'd0);
    send_event(REQ_BEND, 7'd0, 14'd0, 7'd0);
    random_burst(110);

    set_bend_range(6'd48);
    tx_idle_pct = 71;
    rx_idle_pct = 32;
    send_event(REQ_NOTE, 7'd127, 14'd90, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd16383, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd0, 7'd0);
    random_burst(110);

    set_bend_range(6'd63);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_event(REQ_NOTE, 7'd127, 14'd90, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd16383, 7'd0);
    send_event(REQ_NOTE, 7'd0, 14'd90, 7'd0);
    send_event(REQ_BEND, 7'd0, 14'd0, 7'd0);
    // long receiver hold while events keep coming
    hold_req = 1'b1;
    random_burst(110);

    set_bend_range(6'd12);
    tx_idle_pct = 32;
    rx_idle_pct = 71;
    random_burst(110);

    drain();
    $display("sent %0d events, checked %0d control words", events_sent, word_count);
    $display("bend ranges 2, 0, 48, 63 and 12 under sender, receiver and no idling");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
